// ===== design/bbit_pkg.sv =====
package bbit_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int IN_BITS        = 16;
  localparam int RATIO_BITS     = 17;
  localparam int FRAC_BITS      = 16;
  localparam int DIV_STEPS      = FRAC_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OVL,
    S_MUL_I,
    S_MUL_A,
    S_MUL_B,
    S_UNION,
    S_CHECK,
    S_DIV,
    S_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    MUL_INTER,
    MUL_AREA_A,
    MUL_AREA_B
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     ovl;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     take_inter;
    logic     take_area_a;
    logic     add_area_b;
    logic     check;
    logic     div_step;
    logic     update;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/bbit_ctrl.sv =====
module bbit_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bbit_pkg::stat_t stat,
  output bbit_pkg::cmd_t  cmd
);

  bbit_pkg::state_t state, state_next;
  logic [bbit_pkg::DIV_CNT_BITS-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bbit_pkg::S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = bbit_pkg::MUL_INTER;
    unique case (state)
      bbit_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bbit_pkg::S_OVL;
        end
      end
      bbit_pkg::S_OVL: begin
        cmd.ovl    = 1'b1;
        state_next = bbit_pkg::S_MUL_I;
      end
      bbit_pkg::S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bbit_pkg::MUL_INTER;
        state_next  = bbit_pkg::S_MUL_A;
      end
      bbit_pkg::S_MUL_A: begin
        cmd.take_inter = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = bbit_pkg::MUL_AREA_A;
        state_next     = bbit_pkg::S_MUL_B;
      end
      bbit_pkg::S_MUL_B: begin
        cmd.take_area_a = 1'b1;
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = bbit_pkg::MUL_AREA_B;
        state_next      = bbit_pkg::S_UNION;
      end
      bbit_pkg::S_UNION: begin
        cmd.add_area_b = 1'b1;
        state_next     = bbit_pkg::S_CHECK;
      end
      bbit_pkg::S_CHECK: begin
        cmd.check    = 1'b1;
        div_cnt_next = '0;
        state_next   = stat.needs_div ? bbit_pkg::S_DIV : bbit_pkg::S_UPDATE;
      end
      bbit_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + bbit_pkg::DIV_CNT_BITS'(1);
        if (div_cnt == bbit_pkg::DIV_CNT_BITS'(bbit_pkg::DIV_STEPS - 1)) begin
          state_next = bbit_pkg::S_UPDATE;
        end
      end
      bbit_pkg::S_UPDATE: begin
        // a final pair waits here until the output register is free
        if (!stat.last || stat.out_free) begin
          cmd.update = 1'b1;
          state_next = bbit_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bbit_pkg::S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bbit_pkg::S_OVL))
    else $error("accepted transaction did not start the sequence");

  assert property (@(posedge clk) disable iff (rst)
    (state == bbit_pkg::S_UPDATE && stat.last && !stat.out_free)
      |=> (state == bbit_pkg::S_UPDATE))
    else $error("left update while the output register was full");

  assert property (@(posedge clk) disable iff (rst)
    (state == bbit_pkg::S_CHECK && !stat.needs_div) |=> (state == bbit_pkg::S_UPDATE))
    else $error("division started when the ratio was already settled");

endmodule

// ===== design/bbit_datapath.sv =====
module bbit_datapath #(
  parameter int COORD_BITS = bbit_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bbit_pkg::cmd_t                  cmd,
  output bbit_pkg::stat_t                 stat,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_center_x,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_center_y,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_width,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_height,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_center_x,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_center_y,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_width,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_height,
  input  logic                            last_pair,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bbit_pkg::RATIO_BITS-1:0] best_ratio
);

  localparam int CB  = COORD_BITS;
  localparam int OVW = CB + 4;      // signed extent difference, half-lsb units
  localparam int OPW = CB + 2;      // non-negative overlap and multiplier operand
  localparam int PW  = 2 * OPW;
  localparam int AW  = 2 * CB + 3;  // quarter-lsb squared areas and their sums
  localparam int RB  = bbit_pkg::RATIO_BITS;

  logic [CB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic          last;
  logic [OPW-1:0] ow, oh;
  logic          ovl_ok;
  logic [PW-1:0] prod;
  logic [AW-1:0] inter, uni, rem;
  logic [RB-1:0] q, best;

  logic signed [OVW-1:0] dw, dh;
  logic [OPW-1:0] op_a, op_b;
  logic [AW-1:0]  area_prod;
  logic           uni_zero, rem_ge;
  logic [AW:0]    rem_sh, rem_sub;
  logic           div_ge;
  logic [RB-1:0]  best_upd;

  function automatic logic signed [OVW-1:0] ovl_half(
    input logic [CB-1:0] ca, input logic [CB-1:0] sa,
    input logic [CB-1:0] cb, input logic [CB-1:0] sb);
    logic signed [OVW-1:0] la, ra, lb, rb, lft, rgt;
    la  = $signed({3'b000, ca, 1'b0}) - $signed({4'b0000, sa});
    ra  = $signed({3'b000, ca, 1'b0}) + $signed({4'b0000, sa});
    lb  = $signed({3'b000, cb, 1'b0}) - $signed({4'b0000, sb});
    rb  = $signed({3'b000, cb, 1'b0}) + $signed({4'b0000, sb});
    lft = (la > lb) ? la : lb;
    rgt = (ra < rb) ? ra : rb;
    return rgt - lft;
  endfunction

  assign dw = ovl_half(ax, aw, bx, bw);
  assign dh = ovl_half(ay, ah, by, bh);

  always_comb begin
    unique case (cmd.mul_sel)
      bbit_pkg::MUL_INTER: begin
        op_a = ow;
        op_b = oh;
      end
      bbit_pkg::MUL_AREA_A: begin
        op_a = {2'b00, aw};
        op_b = {2'b00, ah};
      end
      bbit_pkg::MUL_AREA_B: begin
        op_a = {2'b00, bw};
        op_b = {2'b00, bh};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // width x height scaled by four to match the half-lsb overlap product
  assign area_prod = {1'b0, prod[2*CB-1:0], 2'b00};

  assign uni_zero = (uni == '0);
  assign rem_ge   = (rem >= uni);

  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, uni};
  assign div_ge  = (rem_sh >= {1'b0, uni});

  assign best_upd = (q > best) ? q : best;

  assign stat.needs_div = !uni_zero && !rem_ge;
  assign stat.last      = last;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax   <= CB'(a_center_x);
      ay   <= CB'(a_center_y);
      aw   <= CB'(a_width);
      ah   <= CB'(a_height);
      bx   <= CB'(b_center_x);
      by   <= CB'(b_center_y);
      bw   <= CB'(b_width);
      bh   <= CB'(b_height);
      last <= last_pair;
    end
    if (cmd.ovl) begin
      ow     <= dw[OPW-1:0];
      oh     <= dh[OPW-1:0];
      ovl_ok <= !dw[OVW-1] && !dh[OVW-1];
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.take_inter) begin
      inter <= ovl_ok ? prod[AW-1:0] : '0;
    end
    if (cmd.take_area_a) begin
      uni <= area_prod - inter;
    end
    if (cmd.add_area_b) begin
      uni <= uni + area_prod;
      rem <= inter;
    end
    if (cmd.check) begin
      q <= (!uni_zero && rem_ge) ? bbit_pkg::RATIO_ONE : '0;
    end
    if (cmd.div_step) begin
      rem <= div_ge ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
      q   <= {q[RB-2:0], div_ge};
    end
    if (cmd.update && last) begin
      best_ratio <= best_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.update && last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.update) begin
        if (last) begin
          best <= '0;
        end else begin
          best <= best_upd;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    best <= bbit_pkg::RATIO_ONE)
    else $error("running best above one");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < uni))
    else $error("division remainder not below the union");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.update && last) |=> (out_valid && best == '0))
    else $error("final pair did not load the output and clear the best");

endmodule

// ===== design/best_box_iou_tracker_core.sv =====
// channel | signals                                   | moves
// input   | in_valid, in_ready, a_*, b_*, last_pair   | one box pair per transaction
// output  | out_valid, out_ready, best_ratio          | best iou of a set, q1.16
//
// an item passes from one acceptance to the next through the accepting idle state,
// an overlap step, three products on one shared multiplier, a union step, a check,
// 16 steps of a restoring divider and an update
// an item whose ratio is settled at the check (zero union, full overlap) skips the divider
// rst is synchronous and clears the sequencer, the running best and out_valid
// a final pair stalls in its update cycle only while a previous result is still held
module best_box_iou_tracker_core #(
  parameter int COORD_BITS = bbit_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_center_x,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_center_y,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_width,
  input  logic [bbit_pkg::IN_BITS-1:0]    a_height,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_center_x,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_center_y,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_width,
  input  logic [bbit_pkg::IN_BITS-1:0]    b_height,
  input  logic                            last_pair,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bbit_pkg::RATIO_BITS-1:0] best_ratio
);

  bbit_pkg::cmd_t  cmd;
  bbit_pkg::stat_t stat;

  bbit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbit_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .a_center_x (a_center_x),
    .a_center_y (a_center_y),
    .a_width    (a_width),
    .a_height   (a_height),
    .b_center_x (b_center_x),
    .b_center_y (b_center_y),
    .b_width    (b_width),
    .b_height   (b_height),
    .last_pair  (last_pair),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_ratio (best_ratio)
  );

endmodule
